// ===== design/mie_pkg.sv =====
// Shared types, constants and functions of the modular inverse core.
// Holds the microcode control word, the status word and the microprogram ROM.
// No dependencies.
package mie_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int PC_W  = 3;
    localparam int IN_DATA_W  = 2 * WIDTH;
    localparam int OUT_DATA_W = 2 * WIDTH;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [PC_W-1:0]  pc_t;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_NOP    = 3'd1,
        OP_DSETUP = 3'd2,
        OP_DIV    = 3'd3,
        OP_ACC    = 3'd4,
        OP_UPD    = 3'd5,
        OP_FIN    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT       = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_WAIT_START = 3'd2,
        COND_R1_ZERO    = 3'd3,
        COND_CNT_NZ     = 3'd4,
        COND_WAIT_OUT   = 3'd5
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        logic  in_ready;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic r1_zero;
        logic cnt_nz;
        logic out_busy;
    } status_t;

    localparam pc_t STEP_IDLE   = 3'd0;
    localparam pc_t STEP_CHK    = 3'd1;
    localparam pc_t STEP_DSETUP = 3'd2;
    localparam pc_t STEP_DIV    = 3'd3;
    localparam pc_t STEP_ACC    = 3'd4;
    localparam pc_t STEP_UPD    = 3'd5;
    localparam pc_t STEP_FIN    = 3'd6;

    function automatic ctrl_t ctrl_rom(input pc_t pc);
        ctrl_t c;
        c = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE, in_ready: 1'b0};
        case (pc)
            STEP_IDLE:   c = '{op: OP_LOAD,   cond: COND_WAIT_START, target: STEP_CHK,
                               in_ready: 1'b1};
            STEP_CHK:    c = '{op: OP_NOP,    cond: COND_R1_ZERO,    target: STEP_FIN,
                               in_ready: 1'b0};
            STEP_DSETUP: c = '{op: OP_DSETUP, cond: COND_NEXT,       target: STEP_IDLE,
                               in_ready: 1'b0};
            STEP_DIV:    c = '{op: OP_DIV,    cond: COND_NEXT,       target: STEP_IDLE,
                               in_ready: 1'b0};
            STEP_ACC:    c = '{op: OP_ACC,    cond: COND_CNT_NZ,     target: STEP_DIV,
                               in_ready: 1'b0};
            STEP_UPD:    c = '{op: OP_UPD,    cond: COND_ALWAYS,     target: STEP_CHK,
                               in_ready: 1'b0};
            STEP_FIN:    c = '{op: OP_FIN,    cond: COND_WAIT_OUT,   target: STEP_IDLE,
                               in_ready: 1'b0};
            default:     c = '{op: OP_NOP,    cond: COND_ALWAYS,     target: STEP_IDLE,
                               in_ready: 1'b0};
        endcase
        return c;
    endfunction

    // Both operands are below m.
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        logic [WIDTH:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= {1'b0, m}) begin
            sum = sum - {1'b0, m};
        end
        return sum[WIDTH-1:0];
    endfunction

    function automatic word_t sub_mod(input word_t x, input word_t y, input word_t m);
        word_t res;
        if (x >= y) begin
            res = x - y;
        end else begin
            res = x + (m - y);
        end
        return res;
    endfunction

endpackage

// ===== design/mie_seq.sv =====
// Microcode sequencer: step counter, control word ROM and jump logic.
// Depends on mie_pkg.
module mie_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  mie_pkg::status_t status,
    output mie_pkg::ctrl_t   ctrl
);
    import mie_pkg::*;

    pc_t pc_reg;
    pc_t pc_next;

    assign ctrl = ctrl_rom(pc_reg);

    always_comb
    begin
        pc_next = pc_reg + 1'b1;
        case (ctrl.cond)
            COND_NEXT:       pc_next = pc_reg + 1'b1;
            COND_ALWAYS:     pc_next = ctrl.target;
            COND_WAIT_START: pc_next = status.start ? ctrl.target : pc_reg;
            COND_R1_ZERO:    pc_next = status.r1_zero ? ctrl.target : pc_reg + 1'b1;
            COND_CNT_NZ:     pc_next = status.cnt_nz ? ctrl.target : pc_reg + 1'b1;
            COND_WAIT_OUT:   pc_next = status.out_busy ? pc_reg : ctrl.target;
            default:         pc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== design/mie_dp.sv =====
// Datapath: remainders, coefficients, restoring divider with modular quotient
// accumulation, and the output register. Depends on mie_pkg.
module mie_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mie_pkg::ctrl_t                  ctrl,
    output mie_pkg::status_t                status,
    input  logic                            in_valid,
    input  logic [mie_pkg::WIDTH-1:0]       value,
    input  logic [mie_pkg::WIDTH-1:0]       modulus,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mie_pkg::WIDTH-1:0]       inverse,
    output logic                            has_inverse,
    output logic [mie_pkg::WIDTH-1:0]       divisor
);
    import mie_pkg::*;

    word_t            r0_reg, r1_reg, s0_reg, s1_reg, m_reg;
    word_t            rem_reg, dvd_reg, acc_reg;
    logic             qbit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    word_t            inv_reg, div_reg;
    logic             ok_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   trial_sub;
    logic             fits;
    logic             out_busy;
    logic             ok_now;

    assign trial     = {rem_reg, dvd_reg[WIDTH-1]};
    assign trial_sub = trial - {1'b0, r1_reg};
    assign fits      = trial >= {1'b0, r1_reg};
    assign out_busy  = out_valid_reg && !out_ready;
    assign ok_now    = (r0_reg == word_t'(1)) && (m_reg != '0);

    assign status.start    = in_valid;
    assign status.r1_zero  = (r1_reg == '0);
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.out_busy = out_busy;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                if (in_valid) begin
                    r0_reg <= value;
                    r1_reg <= modulus;
                    m_reg  <= modulus;
                    s0_reg <= (modulus == word_t'(1)) ? '0 : word_t'(1);
                    s1_reg <= '0;
                end
            end
            OP_DSETUP:
            begin
                rem_reg <= '0;
                dvd_reg <= r0_reg;
                acc_reg <= '0;
                cnt_reg <= CNT_W'(WIDTH - 1);
            end
            OP_DIV:
            begin
                rem_reg  <= fits ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
                qbit_reg <= fits;
                dvd_reg  <= {dvd_reg[WIDTH-2:0], 1'b0};
                acc_reg  <= add_mod(acc_reg, acc_reg, m_reg);
            end
            OP_ACC:
            begin
                if (qbit_reg) begin
                    acc_reg <= add_mod(acc_reg, s1_reg, m_reg);
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_UPD:
            begin
                r0_reg <= r1_reg;
                r1_reg <= rem_reg;
                s0_reg <= s1_reg;
                s1_reg <= sub_mod(s0_reg, acc_reg, m_reg);
            end
            OP_FIN:
            begin
                if (!out_busy) begin
                    div_reg <= r0_reg;
                    ok_reg  <= ok_now;
                    inv_reg <= ok_now ? s0_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.op == OP_FIN && !out_busy) begin
            out_valid_reg <= 1'b1;
        end else if (out_valid_reg && out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign inverse     = inv_reg;
    assign has_inverse = ok_reg;
    assign divisor     = div_reg;

endmodule

// ===== design/modular_inverse_ext_euclid_core.sv =====
// Modular inverse by the extended Euclidean algorithm, microcoded sequencer.
// Each quotient step is one restoring division, with a DIV and an ACC step per quotient bit,
// followed by the remainder and coefficient update.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset (rst_n, asynchronous, active low) clears the step counter and output valid.
// Depends on mie_pkg, mie_seq and mie_dp.
module modular_inverse_ext_euclid_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: value [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH]
    input  logic [mie_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: inverse [WIDTH-1:0], divisor [2*WIDTH-1:WIDTH]
    output logic [mie_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: has_inverse [0]
    output logic                               m_axis_tuser
);
    import mie_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    word_t   inverse;
    word_t   divisor;

    assign s_axis_tready = ctrl.in_ready;

    mie_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    mie_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (s_axis_tvalid),
        .value       (s_axis_tdata[WIDTH-1:0]),
        .modulus     (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .inverse     (inverse),
        .has_inverse (m_axis_tuser),
        .divisor     (divisor)
    );

    assign m_axis_tdata = {divisor, inverse};

endmodule

// ===== tb/sv/tb.sv =====
// Testbench of modular_inverse_ext_euclid_core: streams operand words through the core and
// checks every result word against a behavioral extended Euclid predictor.
// Depends on mie_pkg and the core's RTL.
module tb;
    import mie_pkg::*;

    localparam int    GAP_MAX     = 17;
    localparam int    N_RANDOM    = 1530;
    localparam int    HOLD_AT     = 400;
    localparam int    HOLD_CYCLES = 8000;
    localparam int    IDLE_LIMIT  = 40000;
    localparam int    TAIL_CYCLES = 200;
    localparam word_t WORD_MAX    = '1;

    typedef struct {
        word_t value;
        word_t modulus;
        bit    drain;
    } operand_t;

    typedef struct packed {
        word_t inverse;
        logic  has_inverse;
        word_t divisor;
    } inv_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [IN_DATA_W-1:0]  in_data   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_DATA_W-1:0] out_data;
    logic                  out_has_inv;

    operand_t    operand_q[$];
    inv_result_t inv_due_q[$];
    operand_t    next_op;
    inv_result_t got_res;
    inv_result_t want_res;

    int errors      = 0;
    int fed         = 0;
    int out_count   = 0;
    int in_gap      = 0;
    int out_gap     = 0;
    int out_hold    = 0;
    int idle_cycles = 0;
    bit in_calm     = 1'b0;
    bit out_calm    = 1'b0;

    modular_inverse_ext_euclid_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .m_axis_tuser  (out_has_inv)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Extended Euclid with signed Bezout coefficients; they stay within the modulus in size.
    function automatic inv_result_t mod_inverse(input word_t value, input word_t modulus);
        inv_result_t    res;
        longint unsigned rem_a;
        longint unsigned rem_b;
        longint unsigned quo;
        longint unsigned rem_t;
        longint         coef_a;
        longint         coef_b;
        longint         coef_t;
        longint         mod_s;
        res = '{inverse: '0, has_inverse: 1'b0, divisor: '0};
        if (modulus == '0)
        begin
            res.divisor = value;
            return res;
        end
        rem_a  = value;
        rem_b  = modulus;
        coef_a = 1;
        coef_b = 0;
        while (rem_b != 0)
        begin
            quo    = rem_a / rem_b;
            rem_t  = rem_a - quo * rem_b;
            rem_a  = rem_b;
            rem_b  = rem_t;
            coef_t = coef_a - longint'(quo) * coef_b;
            coef_a = coef_b;
            coef_b = coef_t;
        end
        res.divisor = rem_a[WIDTH-1:0];
        if (rem_a == 1)
        begin
            mod_s  = longint'(modulus);
            coef_t = coef_a % mod_s;
            if (coef_t < 0)
            begin
                coef_t = coef_t + mod_s;
            end
            res.inverse     = coef_t[WIDTH-1:0];
            res.has_inverse = 1'b1;
        end
        return res;
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic word_t rand_word(input int bits);
        word_t w;
        w = $urandom;
        if (bits < WIDTH)
        begin
            w = w & ((word_t'(1) << bits) - 1);
        end
        return w;
    endfunction

    task automatic add_item(input word_t value, input word_t modulus, input bit drain);
        operand_t entry;
        entry     = '{value: value, modulus: modulus, drain: drain};
        operand_q = {operand_q, entry};
    endtask

    // Driver: one operand word at a time, with a random gap after each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                inv_due_q = {inv_due_q, mod_inverse(in_data[WIDTH-1:0],
                                                    in_data[2*WIDTH-1:WIDTH])};
                fed++;
                if (fed % 40 == 0)
                begin
                    in_calm = ($urandom_range(0, 3) == 0);
                end
                in_gap = draw_gap(in_calm);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (operand_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (operand_q[0].drain && fed != out_count)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_op = operand_q.pop_front();
                    in_data  <= {next_op.modulus, next_op.value};
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each result word; stalls the output side at random and in one long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_res = '{inverse: out_data[WIDTH-1:0], has_inverse: out_has_inv,
                            divisor: out_data[2*WIDTH-1:WIDTH]};
                if (inv_due_q.size() == 0)
                begin
                    $error("result word with nothing expected: inverse %0h divisor %0h",
                           got_res.inverse, got_res.divisor);
                    errors++;
                end
                else
                begin
                    want_res = inv_due_q.pop_front();
                    if (got_res.inverse !== want_res.inverse)
                    begin
                        $error("inverse: expected %0h, got %0h",
                               want_res.inverse, got_res.inverse);
                        errors++;
                    end
                    if (got_res.has_inverse !== want_res.has_inverse)
                    begin
                        $error("has_inverse: expected %0b, got %0b",
                               want_res.has_inverse, got_res.has_inverse);
                        errors++;
                    end
                    if (got_res.divisor !== want_res.divisor)
                    begin
                        $error("divisor: expected %0h, got %0h",
                               want_res.divisor, got_res.divisor);
                        errors++;
                    end
                end
                out_count <= out_count + 1;
                if (out_count + 1 == HOLD_AT)
                begin
                    out_hold = HOLD_CYCLES;
                end
                if ((out_count + 1) % 40 == 0)
                begin
                    out_calm = ($urandom_range(0, 3) == 0);
                end
                out_gap = draw_gap(out_calm);
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int    kind;
        word_t v;
        word_t m;
        word_t g;

        add_item(32'd0, 32'd1, 1'b0);
        add_item(32'd0, 32'd7, 1'b0);
        add_item(32'd0, WORD_MAX, 1'b0);
        add_item(32'd1, 32'd1, 1'b0);
        add_item(WORD_MAX, 32'd1, 1'b0);
        add_item(32'd3, 32'd7, 1'b0);
        add_item(32'd7, 32'd7, 1'b0);
        add_item(32'd6, 32'd9, 1'b0);
        add_item(32'd100, 32'd7, 1'b0);
        add_item(32'd1, WORD_MAX, 1'b0);
        add_item(32'd2, WORD_MAX, 1'b0);
        add_item(WORD_MAX, WORD_MAX, 1'b0);
        add_item(WORD_MAX, WORD_MAX - 1, 1'b0);
        add_item(WORD_MAX - 1, WORD_MAX, 1'b0);
        add_item(32'h8000_0000, 32'h8000_0000, 1'b0);
        add_item(32'h8000_0000, WORD_MAX, 1'b0);
        add_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        add_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        add_item(32'd1836311903, 32'd2971215073, 1'b0);
        add_item(32'd2971215073, 32'd1836311903, 1'b0);
        add_item(32'd12, 32'd18, 1'b0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                v = $urandom;
                m = $urandom;
            end
            else if (kind < 65)
            begin
                v = rand_word($urandom_range(1, 14));
                m = rand_word($urandom_range(1, 12));
            end
            else if (kind < 78)
            begin
                g = rand_word($urandom_range(1, 8)) | 32'd2;
                v = g * rand_word(12);
                m = g * rand_word(12);
            end
            else if (kind < 90)
            begin
                v = rand_word($urandom_range(13, 31));
                m = rand_word($urandom_range(13, 32));
            end
            else if (kind < 95)
            begin
                v = ($urandom_range(0, 1) == 0) ? word_t'(0) : word_t'($urandom);
                m = ($urandom_range(0, 1) == 0) ? word_t'(1) : rand_word($urandom_range(1, 32));
            end
            else
            begin
                m = rand_word(16);
                v = m * rand_word(16);
            end
            if (m == '0)
            begin
                m = 32'd1;
            end
            add_item(v, m, (i == 0) || (i == 750) || ($urandom_range(0, 149) == 0));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (operand_q.size() != 0 || in_valid || inv_due_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (inv_due_q.size() != 0)
        begin
            $error("%0d expected result words never arrived", inv_due_q.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
